>>> rtl/sss_pkg.sv
// Shared types, codes and the control-store program for the sort and search store.
// No dependencies; every other file references this package by scoped names.
package sss_pkg;

  // Default sizing
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_DATA_WIDTH = 16;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int VALUE_W = 16;
  localparam int ST_W    = 2;
  localparam int POS_W   = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_LINEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_BINARY = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_LOADED   = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  // Datapath action codes
  localparam int ACT_W = 5;
  localparam logic [ACT_W-1:0] A_NOP       = 5'd0;
  localparam logic [ACT_W-1:0] A_ACCEPT    = 5'd1;
  localparam logic [ACT_W-1:0] A_LOAD      = 5'd2;
  localparam logic [ACT_W-1:0] A_CLEAR     = 5'd3;
  localparam logic [ACT_W-1:0] A_LIN_INIT  = 5'd4;
  localparam logic [ACT_W-1:0] A_READ_J    = 5'd5;
  localparam logic [ACT_W-1:0] A_LIN_CMP   = 5'd6;
  localparam logic [ACT_W-1:0] A_LIN_DONE  = 5'd7;
  localparam logic [ACT_W-1:0] A_SRT_INIT  = 5'd8;
  localparam logic [ACT_W-1:0] A_READ_I    = 5'd9;
  localparam logic [ACT_W-1:0] A_SRT_LOADA = 5'd10;
  localparam logic [ACT_W-1:0] A_SRT_CMP   = 5'd11;
  localparam logic [ACT_W-1:0] A_SRT_WBACK = 5'd12;
  localparam logic [ACT_W-1:0] A_BS_INIT   = 5'd13;
  localparam logic [ACT_W-1:0] A_READ_MID  = 5'd14;
  localparam logic [ACT_W-1:0] A_BS_CMP    = 5'd15;
  localparam logic [ACT_W-1:0] A_BS_NF     = 5'd16;

  // Jump condition codes
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEXT    = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS  = 3'd1;
  localparam logic [COND_W-1:0] C_INVALID = 3'd2;
  localparam logic [COND_W-1:0] C_JEND    = 3'd3;
  localparam logic [COND_W-1:0] C_IEND    = 3'd4;
  localparam logic [COND_W-1:0] C_LOGEHE  = 3'd5;
  localparam logic [COND_W-1:0] C_EQ      = 3'd6;

  // Step addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_IDLE       = 5'd0;
  localparam logic [PC_W-1:0] S_LOAD       = 5'd1;
  localparam logic [PC_W-1:0] S_CLEAR      = 5'd2;
  localparam logic [PC_W-1:0] S_LIN        = 5'd3;
  localparam logic [PC_W-1:0] S_LIN_TEST   = 5'd4;
  localparam logic [PC_W-1:0] S_LIN_CMP    = 5'd5;
  localparam logic [PC_W-1:0] S_LIN_DONE   = 5'd6;
  localparam logic [PC_W-1:0] S_SRT        = 5'd7;
  localparam logic [PC_W-1:0] S_SRT_ITEST  = 5'd8;
  localparam logic [PC_W-1:0] S_SRT_LOADA  = 5'd9;
  localparam logic [PC_W-1:0] S_SRT_JTEST  = 5'd10;
  localparam logic [PC_W-1:0] S_SRT_CMP    = 5'd11;
  localparam logic [PC_W-1:0] S_SRT_WBACK  = 5'd12;
  localparam logic [PC_W-1:0] S_BS         = 5'd13;
  localparam logic [PC_W-1:0] S_BS_TEST    = 5'd14;
  localparam logic [PC_W-1:0] S_BS_CMP     = 5'd15;
  localparam logic [PC_W-1:0] S_BS_LOOP    = 5'd16;
  localparam logic [PC_W-1:0] S_BS_NF      = 5'd17;

  // One control word
  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic j_end;
    logic i_end;
    logic lo_ge_he;
    logic eq;
    logic stall;
  } dp_stat_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      S_IDLE:      w = '{A_ACCEPT,    C_INVALID, S_IDLE};
      S_LOAD:      w = '{A_LOAD,      C_ALWAYS,  S_IDLE};
      S_CLEAR:     w = '{A_CLEAR,     C_ALWAYS,  S_IDLE};
      S_LIN:       w = '{A_LIN_INIT,  C_NEXT,    S_IDLE};
      S_LIN_TEST:  w = '{A_READ_J,    C_JEND,    S_LIN_DONE};
      S_LIN_CMP:   w = '{A_LIN_CMP,   C_ALWAYS,  S_LIN_TEST};
      S_LIN_DONE:  w = '{A_LIN_DONE,  C_ALWAYS,  S_IDLE};
      S_SRT:       w = '{A_SRT_INIT,  C_NEXT,    S_IDLE};
      S_SRT_ITEST: w = '{A_READ_I,    C_IEND,    S_BS};
      S_SRT_LOADA: w = '{A_SRT_LOADA, C_NEXT,    S_IDLE};
      S_SRT_JTEST: w = '{A_READ_J,    C_JEND,    S_SRT_WBACK};
      S_SRT_CMP:   w = '{A_SRT_CMP,   C_ALWAYS,  S_SRT_JTEST};
      S_SRT_WBACK: w = '{A_SRT_WBACK, C_ALWAYS,  S_SRT_ITEST};
      S_BS:        w = '{A_BS_INIT,   C_NEXT,    S_IDLE};
      S_BS_TEST:   w = '{A_READ_MID,  C_LOGEHE,  S_BS_NF};
      S_BS_CMP:    w = '{A_BS_CMP,    C_EQ,      S_IDLE};
      S_BS_LOOP:   w = '{A_NOP,       C_ALWAYS,  S_BS_TEST};
      S_BS_NF:     w = '{A_BS_NF,     C_ALWAYS,  S_IDLE};
      default:     w = '{A_NOP,       C_ALWAYS,  S_IDLE};
    endcase
    return w;
  endfunction

  // Entry step for each operation
  function automatic logic [PC_W-1:0] op_entry(input logic [OP_W-1:0] op);
    logic [PC_W-1:0] s;
    unique case (op)
      OP_LOAD:   s = S_LOAD;
      OP_LINEAR: s = S_LIN;
      OP_BINARY: s = S_SRT;
      OP_CLEAR:  s = S_CLEAR;
      default:   s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/sss_useq.sv
// Step counter and jump logic of the control sequencer; fetches control words
// from the control store. Depends on sss_pkg.
module sss_useq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [sss_pkg::OP_W-1:0]     in_operation,
  input  sss_pkg::dp_stat_t            stat,
  output sss_pkg::ucode_t              uw
);

  logic [sss_pkg::PC_W-1:0] pc_r;
  logic [sss_pkg::PC_W-1:0] pc_nxt;
  logic [sss_pkg::PC_W-1:0] pc_inc;

  // Fetch
  assign uw     = sss_pkg::ucode_rom(pc_r);
  assign pc_inc = pc_r + sss_pkg::PC_W'(1);

  // Select next step; hold while an emit waits on the output register
  always_comb begin
    pc_nxt = pc_r;
    if (!stat.stall) begin
      unique case (uw.cond)
        sss_pkg::C_NEXT:    pc_nxt = pc_inc;
        sss_pkg::C_ALWAYS:  pc_nxt = uw.target;
        sss_pkg::C_INVALID: pc_nxt = in_valid ? sss_pkg::op_entry(in_operation) : pc_r;
        sss_pkg::C_JEND:    pc_nxt = stat.j_end ? uw.target : pc_inc;
        sss_pkg::C_IEND:    pc_nxt = stat.i_end ? uw.target : pc_inc;
        sss_pkg::C_LOGEHE:  pc_nxt = stat.lo_ge_he ? uw.target : pc_inc;
        sss_pkg::C_EQ:      pc_nxt = stat.eq ? uw.target : pc_inc;
        default:            pc_nxt = sss_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sss_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/sss_dpath.sv
// Datapath: value store memory, index counters, compare logic and output register.
// Driven by control words from sss_useq. Depends on sss_pkg.
module sss_dpath #(
  parameter int ENTRIES    = sss_pkg::DEF_ENTRIES,
  parameter int DATA_WIDTH = sss_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sss_pkg::ucode_t                   uw,
  input  logic signed [sss_pkg::VALUE_W-1:0] in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [sss_pkg::ST_W-1:0]          out_status,
  output logic [sss_pkg::POS_W-1:0]         out_position,
  output logic                              out_last,
  output sss_pkg::dp_stat_t                 stat
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam int PW = (CW > sss_pkg::POS_W) ? CW : sss_pkg::POS_W;

  logic [DATA_WIDTH-1:0] mem [ENTRIES];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] he_r, he_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] pend_pos_r, pend_pos_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic signed [DATA_WIDTH-1:0] a_r, a_nxt;
  logic signed [DATA_WIDTH-1:0] key_r, key_nxt;
  logic signed [DATA_WIDTH-1:0] rd_r;

  logic                        out_valid_r;
  logic [sss_pkg::ST_W-1:0]    out_status_r;
  logic [sss_pkg::POS_W-1:0]   out_position_r;
  logic                        out_last_r;

  logic                        emit_req;
  logic [sss_pkg::ST_W-1:0]    emit_status;
  logic [sss_pkg::POS_W-1:0]   emit_pos;
  logic                        emit_last;
  logic                        out_free;
  logic                        stall;

  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [DATA_WIDTH-1:0]       mem_wd;
  logic                        mem_re;
  logic [AW-1:0]               mem_ra;

  logic signed [31:0]          value_ext;
  logic [CW-1:0]               span;
  logic [CW-1:0]               mid_c;
  logic                        full;
  logic                        eq;

  // Map an internal position onto the result field width
  function automatic logic [sss_pkg::POS_W-1:0] to_pos(input logic [CW-1:0] p);
    logic [PW-1:0] e;
    e = PW'(p);
    return e[sss_pkg::POS_W-1:0];
  endfunction

  // Shared compare and index arithmetic
  assign value_ext = 32'(in_value);
  assign full      = (cnt_r >= CW'(ENTRIES));
  assign eq        = (rd_r == key_r);
  assign span      = he_r - lo_r - CW'(1);
  assign mid_c     = lo_r + (span >> 1);
  assign out_free  = !out_valid_r || out_ready;
  assign stall     = emit_req && !out_free;

  assign stat.j_end    = (j_r >= cnt_r);
  assign stat.i_end    = (i_r >= cnt_r);
  assign stat.lo_ge_he = (lo_r >= he_r);
  assign stat.eq       = eq;
  assign stat.stall    = stall;

  // Decode the action of the current step
  always_comb begin
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    lo_nxt       = lo_r;
    he_nxt       = he_r;
    mid_nxt      = mid_r;
    pend_pos_nxt = pend_pos_r;
    pend_v_nxt   = pend_v_r;
    a_nxt        = a_r;
    key_nxt      = key_r;
    emit_req     = 1'b0;
    emit_status  = sss_pkg::ST_NOTFOUND;
    emit_pos     = '0;
    emit_last    = 1'b1;
    mem_we       = 1'b0;
    mem_wa       = cnt_r[AW-1:0];
    mem_wd       = key_r;
    mem_re       = 1'b0;
    mem_ra       = j_r[AW-1:0];
    unique case (uw.act)
      sss_pkg::A_NOP: begin
      end
      sss_pkg::A_ACCEPT: begin
        key_nxt = value_ext[DATA_WIDTH-1:0];
      end
      sss_pkg::A_LOAD: begin
        emit_req = 1'b1;
        if (full) begin
          emit_status = sss_pkg::ST_FULL;
        end else begin
          emit_status = sss_pkg::ST_LOADED;
          mem_we      = 1'b1;
          cnt_nxt     = cnt_r + CW'(1);
        end
      end
      sss_pkg::A_CLEAR: begin
        cnt_nxt = '0;
      end
      sss_pkg::A_LIN_INIT: begin
        j_nxt      = '0;
        pend_v_nxt = 1'b0;
      end
      sss_pkg::A_READ_J: begin
        mem_re = 1'b1;
      end
      sss_pkg::A_LIN_CMP: begin
        // Release the previous match once a later one shows it is not last
        j_nxt = j_r + CW'(1);
        if (eq) begin
          emit_req     = pend_v_r;
          emit_status  = sss_pkg::ST_FOUND;
          emit_pos     = to_pos(pend_pos_r);
          emit_last    = 1'b0;
          pend_v_nxt   = 1'b1;
          pend_pos_nxt = j_r + CW'(1);
        end
      end
      sss_pkg::A_LIN_DONE: begin
        emit_req   = 1'b1;
        pend_v_nxt = 1'b0;
        if (pend_v_r) begin
          emit_status = sss_pkg::ST_FOUND;
          emit_pos    = to_pos(pend_pos_r);
        end
      end
      sss_pkg::A_SRT_INIT: begin
        i_nxt = '0;
      end
      sss_pkg::A_READ_I: begin
        mem_re = 1'b1;
        mem_ra = i_r[AW-1:0];
        j_nxt  = i_r + CW'(1);
      end
      sss_pkg::A_SRT_LOADA: begin
        a_nxt = rd_r;
      end
      sss_pkg::A_SRT_CMP: begin
        // Keep the smaller value for slot i, push the larger one back to slot j
        j_nxt = j_r + CW'(1);
        if (a_r > rd_r) begin
          mem_we = 1'b1;
          mem_wa = j_r[AW-1:0];
          mem_wd = a_r;
          a_nxt  = rd_r;
        end
      end
      sss_pkg::A_SRT_WBACK: begin
        mem_we = 1'b1;
        mem_wa = i_r[AW-1:0];
        mem_wd = a_r;
        i_nxt  = i_r + CW'(1);
      end
      sss_pkg::A_BS_INIT: begin
        lo_nxt = '0;
        he_nxt = cnt_r;
      end
      sss_pkg::A_READ_MID: begin
        mem_re  = 1'b1;
        mem_ra  = mid_c[AW-1:0];
        mid_nxt = mid_c;
      end
      sss_pkg::A_BS_CMP: begin
        if (eq) begin
          emit_req    = 1'b1;
          emit_status = sss_pkg::ST_FOUND;
          emit_pos    = to_pos(mid_r + CW'(1));
        end else if (rd_r > key_r) begin
          he_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + CW'(1);
        end
      end
      sss_pkg::A_BS_NF: begin
        emit_req = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Value store
  always_ff @(posedge clk) begin
    if (mem_we && !stall) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!stall) begin
        cnt_r    <= cnt_nxt;
        pend_v_r <= pend_v_nxt;
      end
      if (emit_req && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!stall) begin
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      lo_r       <= lo_nxt;
      he_r       <= he_nxt;
      mid_r      <= mid_nxt;
      pend_pos_r <= pend_pos_nxt;
      a_r        <= a_nxt;
      key_r      <= key_nxt;
    end
    if (emit_req && out_free) begin
      out_status_r   <= emit_status;
      out_position_r <= emit_pos;
      out_last_r     <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES))
    else $error("loaded count beyond store depth");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    uw.act == sss_pkg::A_ACCEPT |-> !pend_v_r)
    else $error("pending linear match left over at idle");

  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ENTRIES < 32) && out_valid_r && out_status_r == sss_pkg::ST_FOUND
      |-> out_position_r != '0)
    else $error("found result with zero position");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(cnt_r) && $stable(j_r) && $stable(pend_v_r))
    else $error("datapath advanced during output stall");
`endif

endmodule

>>> rtl/sort_and_search_store.sv
// Sort and search store: a store of signed values with load, clear, linear
// query and sort-then-binary query operations.
//
// Input channel (in_valid/in_ready): in_operation selects load (0), linear
// query (1), sort then binary query (2) or clear (3); in_value is the value to
// load or the key. Items are taken one at a time; in_ready is high only while
// the sequencer waits at its idle step.
// Result channel (out_valid/out_ready): out_status, out_position (1-based,
// 0 when none) and out_last, which marks the final result of an item. Clear
// gives no result; a linear query gives one result per match, in store order,
// or a single not-found result when none match. A binary query first sorts
// the store in place, then probes it at most floor(log2 n) + 1 times, where
// n is the number of loaded entries.
// A stalled receiver holds the single output register; the sequencer then
// waits on the step that has a result to hand over and continues once taken.
// Reset empties the store (loaded count zero) and returns to idle; no clearing
// pass is needed.
// Depends on sss_pkg, sss_useq and sss_dpath.
module sort_and_search_store #(
  parameter int ENTRIES    = sss_pkg::DEF_ENTRIES,
  parameter int DATA_WIDTH = sss_pkg::DEF_DATA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sss_pkg::OP_W-1:0]           in_operation,
  input  logic signed [sss_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sss_pkg::ST_W-1:0]           out_status,
  output logic [sss_pkg::POS_W-1:0]          out_position,
  output logic                               out_last
);

  sss_pkg::ucode_t   uw;
  sss_pkg::dp_stat_t stat;

  // Take a transaction only at the idle step
  assign in_ready = (uw.act == sss_pkg::A_ACCEPT);

  sss_useq u_useq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .stat         (stat),
    .uw           (uw)
  );

  sss_dpath #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .uw           (uw),
    .in_value     (in_value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_last     (out_last),
    .stat         (stat)
  );

endmodule
